// ----- src/vsi_pkg.sv -----
// types, constants and helpers shared by the voltage safety interlock
package vsi_pkg;

  localparam logic [7:0] STRIKE_LIMIT = 8'd3;
  localparam logic [7:0] RUN_MAX      = 8'hFF;

  localparam int unsigned THR_W  = 16;
  localparam int unsigned TICK_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_ACK    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    MS_SAFE   = 4'b0001,
    MS_WARN   = 4'b0010,
    MS_DANGER = 4'b0100,
    MS_LOCK   = 4'b1000
  } mode_state_t;

  localparam logic [1:0] MODE_SAFE   = 2'd0;
  localparam logic [1:0] MODE_WARN   = 2'd1;
  localparam logic [1:0] MODE_DANGER = 2'd2;
  localparam logic [1:0] MODE_LOCK   = 2'd3;

  localparam logic [2:0] LVL_NONE   = 3'd0;
  localparam logic [2:0] LVL_LOW    = 3'd1;
  localparam logic [2:0] LVL_MEDIUM = 3'd2;
  localparam logic [2:0] LVL_HIGH   = 3'd3;
  localparam logic [2:0] LVL_CRIT   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_CRIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_AC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DC     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TICKS = 3'd7;

  typedef struct packed {
    op_t               op;
    logic [THR_W-1:0]  voltage;
  } in_t;

  typedef struct packed {
    logic [2:0]        alert_level;
    logic              ac_danger;
    logic              dc_danger;
    logic              sample_safe;
    logic              check_pass;
    logic [1:0]        mode;
    logic              acknowledged;
    logic              can_proceed;
    logic              alert_active;
    logic [TICK_W-1:0] lockout_remaining;
  } out_t;

  typedef struct packed {
    logic              check_enable;
    logic              lockout_enable;
    logic [THR_W-1:0]  thr_critical;
    logic [THR_W-1:0]  thr_mains_high;
    logic [THR_W-1:0]  thr_mains_low;
    logic [THR_W-1:0]  thr_ac_danger;
    logic [THR_W-1:0]  thr_dc_danger;
    logic [TICK_W-1:0] lockout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    check_enable:   1'b1,
    lockout_enable: 1'b1,
    thr_critical:   16'd2500,
    thr_mains_high: 16'd1800,
    thr_mains_low:  16'd900,
    thr_ac_danger:  16'd500,
    thr_dc_danger:  16'd600,
    lockout_ticks:  20'd30000
  };

  function automatic logic [1:0] mode_code(input mode_state_t m);
    logic [1:0] c;
    case (m)
      MS_SAFE:   c = MODE_SAFE;
      MS_WARN:   c = MODE_WARN;
      MS_DANGER: c = MODE_DANGER;
      MS_LOCK:   c = MODE_LOCK;
      default:   c = MODE_SAFE;
    endcase
    return c;
  endfunction

endpackage

// ----- src/voltage_safety_interlock.sv -----
// voltage safety interlock: top level with input stage, state update and result register
// an accepted input beat is held in the input register, then its result is held in the result register
// throughput: one beat per cycle; the input register and the result register advance
//   together whenever the result register is empty or being taken
// reset (rst_n low, synchronous): configuration to its defaults, mode safe, not acknowledged,
//   danger count, lockout countdown and alert flag cleared, both stages empty
module voltage_safety_interlock (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vsi_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vsi_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [vsi_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [vsi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import vsi_pkg::*;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  in_t               s1_data_r;
  logic              out_valid_r;
  out_t              out_data_r;

  mode_state_t       mode_r, mode_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        run_r, run_nxt;
  logic [TICK_W-1:0] cd_r, cd_nxt;
  logic              alert_r, alert_nxt;

  logic              adv;
  logic              s1_fire;
  logic              in_fire;
  logic [2:0]        cls_level;
  logic              cls_dc;
  logic [7:0]        run_inc;
  logic              lock_go;
  out_t              res;

  assign adv      = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vsi_classify u_cls (
    .voltage   (s1_data_r.voltage),
    .cfg       (cfg_r),
    .level     (cls_level),
    .dc_danger (cls_dc)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CHECK_EN:   cfg_r.check_enable   <= cfg_wdata[0];
        REG_LOCKOUT_EN: cfg_r.lockout_enable <= cfg_wdata[0];
        REG_THR_CRIT:   cfg_r.thr_critical   <= cfg_wdata[THR_W-1:0];
        REG_THR_HIGH:   cfg_r.thr_mains_high <= cfg_wdata[THR_W-1:0];
        REG_THR_LOW:    cfg_r.thr_mains_low  <= cfg_wdata[THR_W-1:0];
        REG_THR_AC:     cfg_r.thr_ac_danger  <= cfg_wdata[THR_W-1:0];
        REG_THR_DC:     cfg_r.thr_dc_danger  <= cfg_wdata[THR_W-1:0];
        REG_LOCK_TICKS: cfg_r.lockout_ticks  <= cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // state update and result
  always_comb begin
    mode_nxt  = mode_r;
    ack_nxt   = ack_r;
    run_nxt   = run_r;
    cd_nxt    = cd_r;
    alert_nxt = alert_r;
    res       = '0;
    run_inc   = (run_r == RUN_MAX) ? run_r : run_r + 8'd1;
    lock_go   = 1'b0;
    if (s1_fire) begin
      case (s1_data_r.op)
        OP_SAMPLE: begin
          if (!cfg_r.check_enable) begin
            res.check_pass = 1'b1;
          end else if (mode_r != MS_LOCK) begin
            res.alert_level = cls_level;
            res.ac_danger   = (cls_level != LVL_NONE);
            res.sample_safe = (cls_level == LVL_NONE);
            res.dc_danger   = cls_dc;
            if (cls_level != LVL_NONE) begin
              run_nxt   = run_inc;
              lock_go   = cfg_r.lockout_enable &&
                          ((run_inc >= STRIKE_LIMIT) || (cls_level >= LVL_HIGH));
              alert_nxt = (cls_level != LVL_LOW);
              if (lock_go) begin
                mode_nxt = MS_LOCK;
                cd_nxt   = cfg_r.lockout_ticks;
              end else if (cls_level >= LVL_HIGH) begin
                mode_nxt = MS_DANGER;
              end else if (cls_level == LVL_MEDIUM) begin
                mode_nxt = MS_WARN;
              end else begin
                mode_nxt = MS_SAFE;
              end
            end else begin
              run_nxt        = '0;
              res.check_pass = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (mode_r == MS_LOCK && cd_r != '0) begin
            cd_nxt = cd_r - TICK_W'(1);
          end
        end
        OP_ACK: begin
          ack_nxt  = 1'b1;
          mode_nxt = MS_SAFE;
          cd_nxt   = '0;
        end
        OP_CLEAR: begin
          mode_nxt  = MS_SAFE;
          ack_nxt   = 1'b1;
          run_nxt   = '0;
          cd_nxt    = '0;
          alert_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // lockout ends once the countdown is spent
      if (mode_nxt == MS_LOCK && cd_nxt == '0) begin
        mode_nxt = MS_SAFE;
      end
    end
    res.mode              = mode_code(mode_nxt);
    res.acknowledged      = ack_nxt;
    res.can_proceed       = ack_nxt && (mode_nxt == MS_SAFE || mode_nxt == MS_WARN);
    res.alert_active      = alert_nxt;
    res.lockout_remaining = cd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MS_SAFE;
      ack_r       <= 1'b0;
      run_r       <= '0;
      cd_r        <= '0;
      alert_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      ack_r   <= ack_nxt;
      run_r   <= run_nxt;
      cd_r    <= cd_nxt;
      alert_r <= alert_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mode_r))
    else $error("mode state not one-hot");

  a_lock_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MS_LOCK) |-> (cd_r != '0))
    else $error("lockout held with no ticks left");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_data_r.op == OP_TICK && mode_r == MS_LOCK && cd_r != '0)
      |=> (cd_r == $past(cd_r) - TICK_W'(1)))
    else $error("tick did not count lockout down");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input stage lost a beat under stall");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_data_r.op == OP_CLEAR) |=> (run_r == '0 && !alert_r && ack_r))
    else $error("clear left state behind");

endmodule

// ----- src/vsi_classify.sv -----
// threshold classifier: alert level and dc danger flag of one sample
module vsi_classify (
  input  logic [15:0]  voltage,
  input  vsi_pkg::cfg_t cfg,
  output logic [2:0]   level,
  output logic         dc_danger
);
  import vsi_pkg::*;

  always_comb begin
    if (voltage > cfg.thr_critical) begin
      level = LVL_CRIT;
    end else if (voltage >= cfg.thr_mains_high) begin
      level = LVL_HIGH;
    end else if (voltage >= cfg.thr_mains_low) begin
      level = LVL_MEDIUM;
    end else if (voltage >= cfg.thr_ac_danger) begin
      level = LVL_LOW;
    end else begin
      level = LVL_NONE;
    end
  end

  assign dc_danger = (voltage >= cfg.thr_dc_danger);

endmodule
